[src/harmonic_waveshaper_top_macros.svh]
// ---------------------------------------------------------------------------
// Harmonic waveshaper assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef HARMONIC_WAVESHAPER_TOP_MACROS_SVH
`define HARMONIC_WAVESHAPER_TOP_MACROS_SVH

`ifndef SYNTH
// check that is off while reset is high
`define HWS_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// check that also holds across reset
`define HWS_CHECK_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HWS_CHECK(label, prop, msg)
`define HWS_CHECK_RST(label, prop, msg)
`endif

`endif

[src/hws_pkg.sv]
// ---------------------------------------------------------------------------
// hws_pkg
// Shared widths, constants and types of the harmonic waveshaper.
// ---------------------------------------------------------------------------
package hws_pkg;

   localparam int FRAC       = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SECOND = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THIRD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOURTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIFTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ASYM   = 3'd5;

   localparam logic [CSR_DATA_W-1:0] DRIVE_UNITY = 16'd4096;

   // internal Q28 widths
   localparam int XQ_W      = 30;  // input sample in Q28
   localparam int DRV_W     = 34;  // driven sample
   localparam int PADE_IN_W = 38;  // tanh unit argument
   localparam int TANH_W    = 31;  // tanh unit result
   localparam int QUO_W     = 29;  // pade ratio, at most 1.0
   localparam int HARM_W    = 35;  // harmonic sum
   localparam int SUM_W     = 36;  // fundamental plus harmonics
   localparam int BIAS_W    = 28;

   // latencies in pipeline stages
   localparam int PADE_LAT   = QUO_W + 5;
   localparam int HARM_LAT   = 8;
   localparam int HARM_DLY   = PADE_LAT - HARM_LAT;
   localparam int SUM_DLY    = PADE_LAT + 2;
   localparam int PIPE_DEPTH = 2 * PADE_LAT + 6;

   localparam logic signed [31:0] ONE_Q     = 32'sd268435456;
   localparam logic signed [31:0] TANH_LIM  = 32'sd1207959552;
   localparam logic signed [31:0] K_0P7     = 32'sd187904819;
   localparam logic signed [31:0] K_1P1     = 32'sd295279002;
   localparam logic        [27:0] K_0P1     = 28'd26843546;
   localparam logic        [35:0] PADE_BASE = 36'd7247757312;  // 27.0 in Q28

   typedef struct packed {
      logic [CSR_DATA_W-1:0] h2;
      logic [CSR_DATA_W-1:0] h3;
      logic [CSR_DATA_W-1:0] h4;
      logic [CSR_DATA_W-1:0] h5;
   } amount_type;

endpackage

[src/harmonic_waveshaper_top.sv]
// ---------------------------------------------------------------------------
// harmonic_waveshaper_top
// Pade tanh fundamental plus weighted Chebyshev harmonics, optional bias.
// ---------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled and returns its
// shaped sample after the two tanh units, each with a 29-stage restoring
// divider (one quotient bit per stage). The whole pipeline advances
// together and freezes while rsp_valid is high and rsp_ready low. Write the
// registers only while the pipeline is empty; the bias tanh runs free and
// settles after an asymmetry write, well ahead of any word that follows it.
`include "harmonic_waveshaper_top_macros.svh"

module harmonic_waveshaper_top #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_sample_out,
   input  logic                                  csr_we,
   input  logic [hws_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hws_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import hws_pkg::*;

   localparam int ISH = 29 - SAMPLE_WIDTH;
   localparam int OSH = 31 - SAMPLE_WIDTH;
   localparam logic signed [38:0] MAXV = (39'sd1 <<< (SAMPLE_WIDTH - 1)) - 39'sd1;
   localparam logic signed [38:0] MINV = -(39'sd1 <<< (SAMPLE_WIDTH - 1));

   logic [CSR_DATA_W-1:0] amt2_ff, amt3_ff, amt4_ff, amt5_ff, drive_ff, asym_ff;
   logic [BIAS_W-1:0]     bias_ff;
   logic [43:0]           bias_m;
   amount_type            amt;

   logic                    adv;
   logic [PIPE_DEPTH-1:0]   vld_ff;
   logic signed [XQ_W-1:0]  x_in, x_ff;
   logic signed [46:0]      drv_m;
   logic signed [DRV_W-1:0] drv_ff;
   logic signed [TANH_W-1:0] fund, tanh_z, tanh_b;
   logic signed [HARM_W-1:0] harm;
   logic signed [HARM_W-1:0] hdl_ff [HARM_DLY];
   logic signed [SUM_W-1:0]  y_ff;
   logic signed [SUM_W-1:0]  ydl_ff [SUM_DLY];
   logic signed [SUM_W:0]    ys_ff;
   logic signed [66:0]       z_m;
   logic signed [PADE_IN_W-1:0] z_ff;
   logic signed [SUM_W:0]    fin_v;
   logic signed [38:0]       fin_w, fin_s;
   logic signed [SAMPLE_WIDTH-1:0] out_in, out_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         amt2_ff  <= '0;
         amt3_ff  <= '0;
         amt4_ff  <= '0;
         amt5_ff  <= '0;
         drive_ff <= DRIVE_UNITY;
         asym_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SECOND: amt2_ff  <= csr_wdata;
            CSR_THIRD:  amt3_ff  <= csr_wdata;
            CSR_FOURTH: amt4_ff  <= csr_wdata;
            CSR_FIFTH:  amt5_ff  <= csr_wdata;
            CSR_DRIVE:  drive_ff <= csr_wdata;
            CSR_ASYM:   asym_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign amt    = '{h2: amt2_ff, h3: amt3_ff, h4: amt4_ff, h5: amt5_ff};
   assign bias_m = asym_ff * K_0P1;

   always_ff @(posedge clock) begin
      bias_ff <= BIAS_W'((bias_m + 44'd16384) >> 15);
   end

   // tanh(bias) depends on registers only; runs free
   hws_pade u_pade_bias (
      .clock (clock),
      .en    (1'b1),
      .x_in  (PADE_IN_W'($signed({1'b0, bias_ff}))),
      .y_out (tanh_b)
   );

   // ---------------- pipeline control ----------------
   assign adv       = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = adv && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // ---------------- input to Q28 ----------------
   generate
      if (ISH >= 0) begin : g_in_up
         assign x_in = XQ_W'(req_sample_in) <<< ISH;
      end else begin : g_in_dn
         localparam int RS = -ISH;
         logic signed [32:0] x_r;
         assign x_r  = (33'(req_sample_in) + (33'sd1 <<< (RS - 1))) >>> RS;
         assign x_in = x_r[XQ_W-1:0];
      end
   endgenerate

   assign drv_m = x_ff * $signed({1'b0, drive_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         drv_ff <= DRV_W'((drv_m + 47'sd2048) >>> 12);
      end
   end

   // ---------------- fundamental and harmonics ----------------
   hws_pade u_pade_fund (
      .clock (clock),
      .en    (adv),
      .x_in  (PADE_IN_W'(drv_ff)),
      .y_out (fund)
   );

   hws_harm u_harm (
      .clock    (clock),
      .en       (adv),
      .amt      (amt),
      .drv_in   (drv_ff),
      .harm_out (harm)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         hdl_ff[0] <= harm;
         for (int i = 1; i < HARM_DLY; i++) begin
            hdl_ff[i] <= hdl_ff[i-1];
         end
         y_ff      <= SUM_W'(fund) + SUM_W'(hdl_ff[HARM_DLY-1]);
         ydl_ff[0] <= y_ff;
         for (int i = 1; i < SUM_DLY; i++) begin
            ydl_ff[i] <= ydl_ff[i-1];
         end
         ys_ff <= (SUM_W + 1)'(y_ff) + (SUM_W + 1)'($signed({1'b0, bias_ff}));
         z_ff  <= PADE_IN_W'((z_m + 67'sd134217728) >>> FRAC);
      end
   end

   assign z_m = ys_ff * K_1P1;

   // ---------------- bias path ----------------
   hws_pade u_pade_asym (
      .clock (clock),
      .en    (adv),
      .x_in  (z_ff),
      .y_out (tanh_z)
   );

   // ---------------- output scale and saturate ----------------
   assign fin_v = (asym_ff != '0) ? (SUM_W + 1)'(tanh_z) - (SUM_W + 1)'(tanh_b)
                                  : (SUM_W + 1)'(ydl_ff[SUM_DLY-1]);
   assign fin_w = 39'(fin_v);

   generate
      if (OSH > 0) begin : g_out_dn
         localparam logic signed [38:0] OHALF = 39'sd1 <<< (OSH - 1);
         assign fin_s = (fin_w + OHALF) >>> OSH;
      end else if (OSH == 0) begin : g_out_eq
         assign fin_s = fin_w;
      end else begin : g_out_up
         assign fin_s = fin_w <<< 1;
      end
   endgenerate

   always_comb begin
      if (fin_s > MAXV) begin
         out_in = MAXV[SAMPLE_WIDTH-1:0];
      end else if (fin_s < MINV) begin
         out_in = MINV[SAMPLE_WIDTH-1:0];
      end else begin
         out_in = fin_s[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = vld_ff[PIPE_DEPTH-1];
   assign rsp_sample_out = out_ff;

   // ---------------- checks ----------------
   `HWS_CHECK_RST(a_reset_empties, reset |=> !rsp_valid, "output word valid after reset")
   `HWS_CHECK(a_stall_freezes, !adv |=> $stable(vld_ff), "pipeline moved during stall")
   `HWS_CHECK(a_empty_stays, (vld_ff == '0) && !req_valid |=> (vld_ff == '0), "word from nowhere")

endmodule

[src/hws_pade.sv]
// ---------------------------------------------------------------------------
// hws_pade
// Pipelined Pade tanh: x*(27+x^2)/(27+9x^2), x clamped to +-4.5, Q28.
// Restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module hws_pade (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [hws_pkg::PADE_IN_W-1:0]  x_in,
   output logic signed [hws_pkg::TANH_W-1:0]     y_out
);
   import hws_pkg::*;

   localparam int XC_N = QUO_W + 4;

   logic signed [31:0]       xc_in;
   logic signed [31:0]       xc_ff [XC_N];
   logic signed [63:0]       sq;
   logic        [32:0]       x2_in, x2_ff;
   logic        [33:0]       num_in, num_ff;
   logic        [35:0]       den_in, den_ff;
   logic        [62:0]       dvd;
   logic        [35:0]       rem_ff [QUO_W+1];
   logic        [QUO_W-1:0]  quo_ff [QUO_W+1];
   logic        [QUO_W-1:0]  lo_ff  [QUO_W+1];
   logic        [35:0]       dd_ff  [QUO_W+1];
   logic signed [63:0]       prod;
   logic signed [TANH_W-1:0] y_ff;

   always_comb begin
      if (x_in > PADE_IN_W'(TANH_LIM)) begin
         xc_in = TANH_LIM;
      end else if (x_in < -PADE_IN_W'(TANH_LIM)) begin
         xc_in = -TANH_LIM;
      end else begin
         xc_in = x_in[31:0];
      end
      sq     = xc_ff[0] * xc_ff[0];
      x2_in  = 33'((sq + 64'sd134217728) >>> FRAC);
      num_in = PADE_BASE[33:0] + 34'(x2_ff);
      den_in = PADE_BASE + 36'({x2_ff, 3'b000}) + 36'(x2_ff);
      dvd    = 63'({num_ff, 28'b0}) + 63'(den_ff >> 1);
      prod   = xc_ff[XC_N-1] * $signed({1'b0, quo_ff[QUO_W]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xc_ff[0]  <= xc_in;
         x2_ff     <= x2_in;
         num_ff    <= num_in;
         den_ff    <= den_in;
         rem_ff[0] <= 36'(dvd[62:QUO_W]);
         lo_ff[0]  <= dvd[QUO_W-1:0];
         quo_ff[0] <= '0;
         dd_ff[0]  <= den_ff;
         y_ff      <= TANH_W'((prod + 64'sd134217728) >>> FRAC);
      end
   end

   genvar k;
   generate
      for (k = 1; k < XC_N; k++) begin : g_xc
         always_ff @(posedge clock) begin
            if (en) begin
               xc_ff[k] <= xc_ff[k-1];
            end
         end
      end

      for (k = 0; k < QUO_W; k++) begin : g_div
         logic [36:0] shifted;
         logic        fits;
         always_comb begin
            shifted = {rem_ff[k], lo_ff[k][QUO_W-1-k]};
            fits    = shifted >= {1'b0, dd_ff[k]};
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= fits ? 36'(shifted - {1'b0, dd_ff[k]}) : shifted[35:0];
               quo_ff[k+1] <= {quo_ff[k][QUO_W-2:0], fits};
               lo_ff[k+1]  <= lo_ff[k];
               dd_ff[k+1]  <= dd_ff[k];
            end
         end
      end
   endgenerate

   assign y_out = y_ff;

endmodule

[src/hws_harm.sv]
// ---------------------------------------------------------------------------
// hws_harm
// Chebyshev T2..T5 of the clipped sample, weighted by amount and level,
// summed in eight pipeline stages.
// ---------------------------------------------------------------------------
module hws_harm (
   input  logic                               clock,
   input  logic                               en,
   input  hws_pkg::amount_type                amt,
   input  logic signed [hws_pkg::DRV_W-1:0]   drv_in,
   output logic signed [hws_pkg::HARM_W-1:0]  harm_out
);
   import hws_pkg::*;

   logic signed [29:0] c_in, c_s1_ff, c_s2_ff, c_s3_ff, c_s4_ff;
   logic        [28:0] lvl_in, lvl_s1_ff, lvl_s2_ff, lvl_s3_ff, lvl_s4_ff, lvl_s5_ff;
   logic        [28:0] lvl_s6_ff;
   logic signed [29:0] sq_s2_ff, sq_s3_ff, qd_s3_ff;
   logic signed [31:0] p3_s3_ff, t2_s3_ff, t2_s4_ff, t3_s4_ff, t4_s4_ff, p5_s4_ff;
   logic signed [31:0] t5_s5_ff, a2_s5_ff, a3_s5_ff, a4_s5_ff;
   logic signed [31:0] a5_s6_ff, w2_s6_ff, w3_s6_ff, w4_s6_ff;
   logic signed [31:0] w2_s7_ff, w3_s7_ff, w4_s7_ff, w5_s7_ff;
   logic signed [HARM_W-1:0] harm_ff;

   logic signed [59:0] m_sq, m_qd;
   logic signed [61:0] m_t3, m_t5;
   logic signed [35:0] t4_w, p5_w;
   logic signed [48:0] m_a2, m_a3, m_a4, m_a5;
   logic signed [61:0] m_w2, m_w3, m_w4, m_w5;
   logic signed [63:0] m_w4b;
   logic signed [29:0] lvl6;

   always_comb begin
      if (drv_in > DRV_W'(ONE_Q)) begin
         c_in = ONE_Q[29:0];
      end else if (drv_in < -DRV_W'(ONE_Q)) begin
         c_in = -ONE_Q[29:0];
      end else begin
         c_in = drv_in[29:0];
      end
      lvl_in = c_in[29] ? 29'(-c_in) : c_in[28:0];

      m_sq = c_s1_ff * c_s1_ff;
      m_qd = sq_s2_ff * sq_s2_ff;
      m_t3 = c_s3_ff * p3_s3_ff;
      t4_w = (36'(qd_s3_ff) <<< 3) - (36'(sq_s3_ff) <<< 3) + 36'(ONE_Q);
      p5_w = (36'(qd_s3_ff) <<< 4) - (36'(sq_s3_ff) <<< 4) - (36'(sq_s3_ff) <<< 2)
           + 36'sd1342177280;
      m_t5 = c_s4_ff * p5_s4_ff;
      m_a2 = t2_s4_ff * $signed({1'b0, amt.h2});
      m_a3 = t3_s4_ff * $signed({1'b0, amt.h3});
      m_a4 = t4_s4_ff * $signed({1'b0, amt.h4});
      m_a5 = t5_s5_ff * $signed({1'b0, amt.h5});
      m_w2 = a2_s5_ff * $signed({1'b0, lvl_s5_ff});
      m_w3 = a3_s5_ff * $signed({1'b0, lvl_s5_ff});
      m_w4 = a4_s5_ff * $signed({1'b0, lvl_s5_ff});
      lvl6 = $signed({1'b0, lvl_s6_ff});
      m_w5 = a5_s6_ff * lvl6;
      m_w4b = w4_s6_ff * K_0P7;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // clip and level
         c_s1_ff   <= c_in;
         lvl_s1_ff <= lvl_in;
         // c^2
         c_s2_ff   <= c_s1_ff;
         lvl_s2_ff <= lvl_s1_ff;
         sq_s2_ff  <= 30'((m_sq + 60'sd134217728) >>> FRAC);
         // c^4, T2, 4c^2-3
         c_s3_ff   <= c_s2_ff;
         lvl_s3_ff <= lvl_s2_ff;
         sq_s3_ff  <= sq_s2_ff;
         qd_s3_ff  <= 30'((m_qd + 60'sd134217728) >>> FRAC);
         p3_s3_ff  <= (32'(sq_s2_ff) <<< 2) - 32'sd805306368;
         t2_s3_ff  <= (32'(sq_s2_ff) <<< 1) - ONE_Q;
         // T3, T4, inner of T5
         c_s4_ff   <= c_s3_ff;
         lvl_s4_ff <= lvl_s3_ff;
         t2_s4_ff  <= t2_s3_ff;
         t3_s4_ff  <= 32'((m_t3 + 62'sd134217728) >>> FRAC);
         t4_s4_ff  <= t4_w[31:0];
         p5_s4_ff  <= p5_w[31:0];
         // T5, amounts
         lvl_s5_ff <= lvl_s4_ff;
         t5_s5_ff  <= 32'((m_t5 + 62'sd134217728) >>> FRAC);
         a2_s5_ff  <= 32'((m_a2 + 49'sd16384) >>> 15);
         a3_s5_ff  <= 32'((m_a3 + 49'sd16384) >>> 15);
         a4_s5_ff  <= 32'((m_a4 + 49'sd16384) >>> 15);
         // level weighting
         lvl_s6_ff <= lvl_s5_ff;
         a5_s6_ff  <= 32'((m_a5 + 49'sd16384) >>> 15);
         w2_s6_ff  <= 32'((m_w2 + 62'sd134217728) >>> FRAC);
         w3_s6_ff  <= 32'((m_w3 + 62'sd134217728) >>> FRAC);
         w4_s6_ff  <= 32'((m_w4 + 62'sd134217728) >>> FRAC);
         // extra factors
         w2_s7_ff  <= w2_s6_ff;
         w3_s7_ff  <= w3_s6_ff;
         w4_s7_ff  <= 32'((m_w4b + 64'sd134217728) >>> FRAC);
         w5_s7_ff  <= 32'((m_w5 + 62'sd134217728) >>> FRAC);
         // sum, T5 term halved
         harm_ff   <= HARM_W'(w2_s7_ff) + HARM_W'(w3_s7_ff) + HARM_W'(w4_s7_ff)
                    + HARM_W'((33'(w5_s7_ff) + 33'sd1) >>> 1);
      end
   end

   assign harm_out = harm_ff;

endmodule
